### hdl/pru_pkg.sv
`timescale 1ns / 1ps
package pru_pkg;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int POS_FRAC_DEF = 16;
	localparam int QUAT_FRAC_DEF = 30;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_UPDATE = 2'd1
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_RND,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIV_START,
		ST_DIV,
		ST_DIV_END,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic update_pos;
		logic mul_step;
		logic mul_clear;
		logic round;
		logic shift_step;
		logic sq_step;
		logic sqrt_init;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic div_store;
	} cmd_t;

	typedef struct packed {
		logic mul_last;
		logic shift_done;
		logic sq_last;
		logic sqrt_done;
		logic div_done;
		logic div_last;
	} status_t;
endpackage

### hdl/pru_if.sv
`timescale 1ns / 1ps
interface pru_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [31:0] lin_x, lin_y, lin_z;
	logic signed [31:0] ang_x, ang_y, ang_z, ang_w;
	modport source(output valid, kind, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, ang_w,
		input ready);
	modport sink(input valid, kind, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, ang_w,
		output ready);
endinterface

interface pru_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
	modport source(output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
		input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
		output ready);
endinterface

### hdl/pru_ctrl.sv
`timescale 1ns / 1ps
module pru_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_kind,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output pru_pkg::cmd_t cmd,
	input  pru_pkg::status_t status
);
	import pru_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind) begin
						cmd.update_pos = 1'b1;
						cmd.mul_clear = 1'b1;
						state_d = ST_MUL;
					end else begin
						cmd.load = 1'b1;
						state_d = ST_OUT;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.mul_last) begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				cmd.round = 1'b1;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (status.shift_done) begin
					state_d = ST_SQ;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			ST_SQ: begin
				cmd.sq_step = 1'b1;
				if (status.sq_last) begin
					state_d = ST_SQRT;
					cmd.sqrt_init = 1'b1;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (status.sqrt_done) begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				cmd.div_store = 1'b1;
				state_d = status.div_last ? ST_OUT : ST_DIV_START;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hdl/pru_datapath.sv
`timescale 1ns / 1ps
module pru_datapath #(
	parameter int WORD_WIDTH = pru_pkg::WORD_WIDTH_DEF,
	parameter int POS_FRAC = pru_pkg::POS_FRAC_DEF,
	parameter int QUAT_FRAC = pru_pkg::QUAT_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  pru_pkg::cmd_t cmd,
	output pru_pkg::status_t status,
	input  logic signed [WORD_WIDTH-1:0] lin [3],
	input  logic signed [WORD_WIDTH-1:0] ang [4],
	output logic signed [WORD_WIDTH-1:0] pos [3],
	output logic signed [WORD_WIDTH-1:0] quat [4]
);
	import pru_pkg::*;

	localparam int W = WORD_WIDTH;
	localparam int PW = 2 * W;
	localparam int AW = PW + 3;
	localparam int RW = AW - QUAT_FRAC + 1;
	localparam int SW = 66;
	localparam int DW = 32 + QUAT_FRAC + 1;
	localparam int POSL = POS_FRAC;
	localparam logic signed [RW-1:0] LIM = RW'(64'sd2147483647);

	logic signed [W-1:0] pos_q [3];
	logic signed [W-1:0] quat_q [4];
	logic signed [W-1:0] dv_q [3];
	logic signed [AW-1:0] acc_q [4];
	logic [3:0] mcnt_q;
	logic signed [RW-1:0] r_q [4];
	logic [1:0] sidx_q;
	logic [SW-1:0] ssum_q;
	logic [SW-1:0] srem_q, sres_q, sbit_q;
	logic [1:0] didx_q;
	logic [DW-1:0] drem_q, dquo_q;
	logic [6:0] dcnt_q;
	logic [32:0] n_q;

	logic signed [W-1:0] dw_c;
	logic signed [W-1:0] aop, bop;
	logic signed [PW-1:0] prod;
	logic [1:0] comp;
	logic neg;
	logic [RW-1:0] mag [4];
	logic big;

	assign dw_c = W'(64'sd1 <<< QUAT_FRAC);

	// Multiply schedule: count 0..15, component = count[3:2], term = count[1:0].
	always_comb begin
		logic [1:0] t;
		logic signed [W-1:0] d [4];
		comp = mcnt_q[3:2];
		t = mcnt_q[1:0];
		d[0] = dw_c; d[1] = dv_q[0]; d[2] = dv_q[1]; d[3] = dv_q[2];
		case (t)
			2'd0: aop = quat_q[3];
			2'd1: aop = quat_q[0];
			2'd2: aop = quat_q[1];
			default: aop = quat_q[2];
		endcase
		bop = d[0];
		neg = 1'b0;
		case (comp)
			2'd0: begin
				case (t)
					2'd0: bop = d[1];
					2'd1: bop = d[0];
					2'd2: bop = d[3];
					default: begin bop = d[2]; neg = 1'b1; end
				endcase
			end
			2'd1: begin
				case (t)
					2'd0: bop = d[2];
					2'd1: begin bop = d[3]; neg = 1'b1; end
					2'd2: bop = d[0];
					default: bop = d[1];
				endcase
			end
			2'd2: begin
				case (t)
					2'd0: bop = d[3];
					2'd1: bop = d[2];
					2'd2: begin bop = d[1]; neg = 1'b1; end
					default: bop = d[0];
				endcase
			end
			default: begin
				case (t)
					2'd0: bop = d[0];
					2'd1: begin bop = d[1]; neg = 1'b1; end
					2'd2: begin bop = d[2]; neg = 1'b1; end
					default: begin bop = d[3]; neg = 1'b1; end
				endcase
			end
		endcase
		prod = aop * bop;
	end

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = r_q[i][RW-1] ? RW'(-r_q[i]) : RW'(r_q[i]);
			if ($signed(mag[i]) > LIM) big = 1'b1;
		end
	end

	logic signed [RW-1:0] rsel;
	logic [SW-1:0] sqv;
	logic [SW-1:0] trial;
	logic [RW-1:0] rmag;
	logic [32:0] qrnd;
	logic signed [W+1:0] qsig;

	assign rsel = r_q[sidx_q];
	assign sqv = SW'($unsigned(64'(rsel) * 64'(rsel)));
	assign trial = sres_q + sbit_q;
	assign rmag = r_q[didx_q][RW-1] ? RW'(-r_q[didx_q]) : RW'(r_q[didx_q]);

	always_comb begin
		qrnd = dquo_q[32:0];
		qsig = r_q[didx_q][RW-1] ? -$signed({1'b0, (W+1)'(qrnd)}) : $signed({1'b0, (W+1)'(qrnd)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) pos_q[i] <= '0;
			for (int i = 0; i < 3; i++) quat_q[i] <= '0;
			quat_q[3] <= dw_c;
		end else begin
			if (cmd.load) begin
				for (int i = 0; i < 3; i++) pos_q[i] <= lin[i];
				for (int i = 0; i < 4; i++) quat_q[i] <= ang[i];
			end
			if (cmd.update_pos) begin
				for (int i = 0; i < 3; i++) begin
					logic signed [W:0] s;
					s = {pos_q[i][W-1], pos_q[i]} + {lin[i][W-1], lin[i]};
					if (s[W] != s[W-1])
						pos_q[i] <= s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
					else
						pos_q[i] <= s[W-1:0];
				end
			end
			if (cmd.div_store) begin
				if (n_q == '0) begin
					quat_q[didx_q] <= W'(r_q[didx_q]);
				end else if (qsig > $signed({2'b00, {(W-1){1'b1}}})) begin
					quat_q[didx_q] <= {1'b0, {(W-1){1'b1}}};
				end else if (qsig < -$signed({2'b01, {(W-1){1'b0}}})) begin
					quat_q[didx_q] <= {1'b1, {(W-1){1'b0}}};
				end else begin
					quat_q[didx_q] <= qsig[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update_pos) begin
			for (int i = 0; i < 3; i++) dv_q[i] <= ang[i] >>> 1;
		end
		if (cmd.mul_clear) begin
			mcnt_q <= '0;
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
		end
		if (cmd.mul_step) begin
			mcnt_q <= mcnt_q + 4'd1;
			acc_q[comp] <= neg ? acc_q[comp] - AW'(prod) : acc_q[comp] + AW'(prod);
		end
		if (cmd.round) begin
			for (int i = 0; i < 4; i++)
				r_q[i] <= RW'(acc_q[i] >>> QUAT_FRAC) + RW'(acc_q[i][QUAT_FRAC-1]);
			sidx_q <= '0;
			ssum_q <= '0;
		end
		if (cmd.shift_step) begin
			for (int i = 0; i < 4; i++) r_q[i] <= r_q[i] >>> 1;
		end
		if (cmd.sq_step) begin
			ssum_q <= ssum_q + sqv;
			sidx_q <= sidx_q + 2'd1;
		end
		if (cmd.sqrt_init) begin
			srem_q <= ssum_q + sqv;
			sres_q <= '0;
			sbit_q <= SW'(1) << 64;
		end
		if (cmd.sqrt_step) begin
			if (sbit_q != '0) begin
				if (srem_q >= trial) begin
					srem_q <= srem_q - trial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end else begin
				n_q <= sres_q[32:0];
				didx_q <= '0;
			end
		end
		if (cmd.div_init) begin
			drem_q <= '0;
			dquo_q <= (DW'(rmag) << QUAT_FRAC) + DW'(n_q >> 1);
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			logic [DW:0] rm;
			rm = {drem_q, dquo_q[DW-1]};
			if (rm >= {{(DW-32){1'b0}}, n_q}) begin
				drem_q <= DW'(rm - {{(DW-32){1'b0}}, n_q});
				dquo_q <= {dquo_q[DW-2:0], 1'b1};
			end else begin
				drem_q <= rm[DW-1:0];
				dquo_q <= {dquo_q[DW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 7'd1;
		end
		if (cmd.div_store) begin
			didx_q <= didx_q + 2'd1;
		end
	end

	assign status.mul_last = (mcnt_q == 4'd15);
	assign status.shift_done = !big;
	assign status.sq_last = (sidx_q == 2'd3);
	assign status.sqrt_done = (sbit_q == '0);
	assign status.div_done = (dcnt_q == 7'(DW - 1));
	assign status.div_last = (didx_q == 2'd3);

	assign pos = pos_q;
	assign quat = quat_q;
endmodule

### hdl/pose_retraction_update_unit.sv
// A load copies the inputs into the pose; an update runs 16 multiply-accumulates,
// up to 3 normalizing shifts, 4 squares, a 33-step square root and four 63-step
// restoring divisions.
// Throughput: one transaction at a time; the serial divider sets the update rate.
// Reset: arst_n clears the position to zero and sets the quaternion to identity.
`timescale 1ns / 1ps
module pose_retraction_update_unit #(
	parameter int WORD_WIDTH = pru_pkg::WORD_WIDTH_DEF,
	parameter int POS_FRAC = pru_pkg::POS_FRAC_DEF,
	parameter int QUAT_FRAC = pru_pkg::QUAT_FRAC_DEF
) (
	input logic clk,
	input logic arst_n,
	pru_in_if.sink in_ch,
	pru_out_if.source out_ch
);
	import pru_pkg::*;

	cmd_t cmd;
	status_t status;
	logic signed [WORD_WIDTH-1:0] lin [3];
	logic signed [WORD_WIDTH-1:0] ang [4];
	logic signed [WORD_WIDTH-1:0] pos [3];
	logic signed [WORD_WIDTH-1:0] quat [4];

	assign lin[0] = in_ch.lin_x;
	assign lin[1] = in_ch.lin_y;
	assign lin[2] = in_ch.lin_z;
	assign ang[0] = in_ch.ang_x;
	assign ang[1] = in_ch.ang_y;
	assign ang[2] = in_ch.ang_z;
	assign ang[3] = in_ch.ang_w;

	pru_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .status(status)
	);

	pru_datapath #(.WORD_WIDTH(WORD_WIDTH), .POS_FRAC(POS_FRAC), .QUAT_FRAC(QUAT_FRAC)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.lin(lin), .ang(ang), .pos(pos), .quat(quat)
	);

	assign out_ch.pos_x = pos[0];
	assign out_ch.pos_y = pos[1];
	assign out_ch.pos_z = pos[2];
	assign out_ch.quat_x = quat[0];
	assign out_ch.quat_y = quat[1];
	assign out_ch.quat_z = quat[2];
	assign out_ch.quat_w = quat[3];

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !in_ch.kind) |=> (out_ch.valid && pos[0] == $past(in_ch.lin_x)))
		else $error("load not echoed");
	a_stable_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> $stable(quat[3])) else $error("result changed");
endmodule
